// ===== src/video_jitter_buffer_macros.svh =====
// Assertion helpers used by the jitter buffer datapath RTL.
`ifndef VIDEO_JITTER_BUFFER_MACROS_SVH
`define VIDEO_JITTER_BUFFER_MACROS_SVH

`define JVB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define JVB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/jvb_pkg.sv =====
package jvb_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [6:0] frames_type;

   localparam cnt_type DEPTH_CNT = cnt_type'(STORE_DEPTH);
   localparam cnt_type EXPIRE_MIN_FRAMES = cnt_type'(3);
   localparam logic [13:0] DELAY_RESET = 14'd500;
   localparam logic [6:0] LOW_WATER_RESET = 7'd5;

   typedef struct packed {
      logic [31:0] ts;
      logic [15:0] seq;
      logic [15:0] handle;
   } entry_type;

   typedef enum logic [2:0] {
      FN_ENQ     = 3'd0,
      FN_DEQ     = 3'd1,
      FN_EXP     = 3'd2,
      FN_RESTART = 3'd3,
      FN_CLEAR   = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      RS_NEW       = 4'd0,
      RS_JOINED    = 4'd1,
      RS_DUP       = 4'd2,
      RS_MUTED     = 4'd3,
      RS_MISMATCH  = 4'd4,
      RS_NOT_READY = 4'd5,
      RS_EMPTY     = 4'd6,
      RS_DELIVERED = 4'd7,
      RS_DONE      = 4'd8,
      RS_FULL      = 4'd9
   } rsp_status_type;

   typedef enum logic [1:0] {
      CSR_DELAY     = 2'd0,
      CSR_PT_FILTER = 2'd1,
      CSR_MUTE      = 2'd2,
      CSR_LOW_WATER = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_PTR,
      RD_PTR_M1
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SCAN_END,
      S_UP_RD,
      S_UP_WR,
      S_INS,
      S_DLV_RD,
      S_DLV_OUT,
      S_DLV_WAIT,
      S_DN_RD,
      S_DN_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic           load_item;
      logic           set_start;
      logic           clear_start;
      logic           clear_store;
      logic           scan_init;
      logic           scan_step;
      logic           scan_miss;
      logic           scan_stop;
      logic           up_init;
      logic           wr_up;
      logic           ins;
      logic           dlv_init;
      logic           dlv_next;
      logic           dn_init;
      logic           dn_step;
      logic           dn_finish;
      logic           resp_load;
      logic           resp_entry;
      rd_sel_type     rd_sel;
      rsp_status_type resp_code;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     mute_drop;
      logic     type_drop;
      logic     not_ready;
      logic     held_zero;
      logic     expire_ok;
      logic     scan_at_end;
      logic     scan_cont;
      logic     dup;
      logic     full;
      logic     joins;
      logic     up_done;
      logic     dlv_last;
      logic     dn_done;
      logic     m_zero;
   } stat_type;

endpackage

// ===== src/jvb_ram.sv =====
module jvb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/jvb_ctrl.sv =====
module jvb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  jvb_pkg::stat_type stat,
   output jvb_pkg::cmd_type  cmd
);

   jvb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jvb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jvb_pkg::S_IDLE: begin
            if (req_valid) state_in = jvb_pkg::S_DECODE;
         end
         jvb_pkg::S_DECODE: begin
            state_in = jvb_pkg::S_RESP;
            case (stat.func)
               jvb_pkg::FN_ENQ: begin
                  if (!stat.mute_drop && !stat.type_drop) state_in = jvb_pkg::S_SCAN_RD;
               end
               jvb_pkg::FN_DEQ: begin
                  if (!stat.not_ready && !stat.held_zero) state_in = jvb_pkg::S_SCAN_RD;
               end
               jvb_pkg::FN_EXP: begin
                  if (stat.expire_ok && !stat.held_zero) state_in = jvb_pkg::S_SCAN_RD;
               end
               default: state_in = jvb_pkg::S_RESP;
            endcase
         end
         jvb_pkg::S_SCAN_RD: begin
            state_in = stat.scan_at_end ? jvb_pkg::S_SCAN_END : jvb_pkg::S_SCAN_CHK;
         end
         jvb_pkg::S_SCAN_CHK: begin
            state_in = stat.scan_cont ? jvb_pkg::S_SCAN_RD : jvb_pkg::S_SCAN_END;
         end
         jvb_pkg::S_SCAN_END: begin
            state_in = jvb_pkg::S_RESP;
            case (stat.func)
               jvb_pkg::FN_ENQ: begin
                  if (!stat.dup && !stat.full) state_in = jvb_pkg::S_UP_RD;
               end
               jvb_pkg::FN_DEQ: state_in = jvb_pkg::S_DLV_RD;
               jvb_pkg::FN_EXP: begin
                  if (!stat.m_zero) state_in = jvb_pkg::S_DN_RD;
               end
               default: state_in = jvb_pkg::S_RESP;
            endcase
         end
         jvb_pkg::S_UP_RD: begin
            state_in = stat.up_done ? jvb_pkg::S_INS : jvb_pkg::S_UP_WR;
         end
         jvb_pkg::S_UP_WR: state_in = jvb_pkg::S_UP_RD;
         jvb_pkg::S_INS: state_in = jvb_pkg::S_RESP;
         jvb_pkg::S_DLV_RD: state_in = jvb_pkg::S_DLV_OUT;
         jvb_pkg::S_DLV_OUT: state_in = jvb_pkg::S_DLV_WAIT;
         jvb_pkg::S_DLV_WAIT: begin
            if (rsp_ready) begin
               state_in = stat.dlv_last ? jvb_pkg::S_DN_RD : jvb_pkg::S_DLV_RD;
            end
         end
         jvb_pkg::S_DN_RD: begin
            if (stat.dn_done) begin
               state_in = (stat.func == jvb_pkg::FN_DEQ) ? jvb_pkg::S_IDLE : jvb_pkg::S_RESP;
            end else begin
               state_in = jvb_pkg::S_DN_WR;
            end
         end
         jvb_pkg::S_DN_WR: state_in = jvb_pkg::S_DN_RD;
         jvb_pkg::S_RESP: begin
            if (rsp_ready) state_in = jvb_pkg::S_IDLE;
         end
         default: state_in = jvb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = jvb_pkg::RD_IDX;
      cmd.resp_code = jvb_pkg::RS_DONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         jvb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = req_valid;
         end
         jvb_pkg::S_DECODE: begin
            cmd.resp_load = 1'b1;
            case (stat.func)
               jvb_pkg::FN_ENQ: begin
                  if (stat.mute_drop) begin
                     cmd.resp_code = jvb_pkg::RS_MUTED;
                  end else if (stat.type_drop) begin
                     cmd.resp_code = jvb_pkg::RS_MISMATCH;
                  end else begin
                     cmd.resp_load = 1'b0;
                     cmd.set_start = 1'b1;
                     cmd.scan_init = 1'b1;
                  end
               end
               jvb_pkg::FN_DEQ: begin
                  if (stat.not_ready) begin
                     cmd.resp_code = jvb_pkg::RS_NOT_READY;
                  end else if (stat.held_zero) begin
                     cmd.resp_code = jvb_pkg::RS_EMPTY;
                  end else begin
                     cmd.resp_load = 1'b0;
                     cmd.scan_init = 1'b1;
                  end
               end
               jvb_pkg::FN_EXP: begin
                  if (stat.expire_ok && !stat.held_zero) begin
                     cmd.resp_load = 1'b0;
                     cmd.scan_init = 1'b1;
                  end
               end
               jvb_pkg::FN_RESTART: cmd.clear_start = 1'b1;
               jvb_pkg::FN_CLEAR: cmd.clear_store = 1'b1;
               default: cmd.resp_code = jvb_pkg::RS_DONE;
            endcase
         end
         jvb_pkg::S_SCAN_RD: begin
            cmd.rd_sel = jvb_pkg::RD_IDX;
            cmd.scan_miss = stat.scan_at_end;
         end
         jvb_pkg::S_SCAN_CHK: begin
            cmd.scan_step = stat.scan_cont;
            cmd.scan_stop = !stat.scan_cont;
         end
         jvb_pkg::S_SCAN_END: begin
            case (stat.func)
               jvb_pkg::FN_ENQ: begin
                  if (stat.dup) begin
                     cmd.resp_load = 1'b1;
                     cmd.resp_code = jvb_pkg::RS_DUP;
                  end else if (stat.full) begin
                     cmd.resp_load = 1'b1;
                     cmd.resp_code = jvb_pkg::RS_FULL;
                  end else begin
                     cmd.up_init = 1'b1;
                  end
               end
               jvb_pkg::FN_DEQ: cmd.dlv_init = 1'b1;
               jvb_pkg::FN_EXP: begin
                  if (stat.m_zero) begin
                     cmd.resp_load = 1'b1;
                  end else begin
                     cmd.dn_init = 1'b1;
                  end
               end
               default: cmd.resp_load = 1'b1;
            endcase
         end
         jvb_pkg::S_UP_RD: cmd.rd_sel = jvb_pkg::RD_PTR_M1;
         jvb_pkg::S_UP_WR: cmd.wr_up = 1'b1;
         jvb_pkg::S_INS: begin
            cmd.ins = 1'b1;
            cmd.resp_load = 1'b1;
            cmd.resp_code = stat.joins ? jvb_pkg::RS_JOINED : jvb_pkg::RS_NEW;
         end
         jvb_pkg::S_DLV_RD: cmd.rd_sel = jvb_pkg::RD_PTR;
         jvb_pkg::S_DLV_OUT: begin
            cmd.resp_load = 1'b1;
            cmd.resp_entry = 1'b1;
            cmd.resp_code = jvb_pkg::RS_DELIVERED;
         end
         jvb_pkg::S_DLV_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.dn_init = stat.dlv_last;
               cmd.dlv_next = !stat.dlv_last;
            end
         end
         jvb_pkg::S_DN_RD: begin
            cmd.rd_sel = jvb_pkg::RD_PTR;
            if (stat.dn_done) begin
               cmd.dn_finish = 1'b1;
               cmd.resp_load = (stat.func != jvb_pkg::FN_DEQ);
            end
         end
         jvb_pkg::S_DN_WR: cmd.dn_step = 1'b1;
         jvb_pkg::S_RESP: rsp_valid = 1'b1;
         default: cmd.rd_sel = jvb_pkg::RD_IDX;
      endcase
   end

endmodule

// ===== src/jvb_dp.sv =====
`include "video_jitter_buffer_macros.svh"

module jvb_dp (
   input  logic              clock,
   input  logic              reset,
   input  jvb_pkg::cmd_type  cmd,
   output jvb_pkg::stat_type stat,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [13:0]       csr_wr_data,
   input  logic [2:0]        req_func,
   input  logic [31:0]       req_rtp_timestamp,
   input  logic [15:0]       req_seq_number,
   input  logic [6:0]        req_payload_kind,
   input  logic [15:0]       req_packet_handle,
   input  logic [31:0]       req_now_ms,
   input  logic [31:0]       req_expire_limit,
   output logic [3:0]        rsp_status,
   output logic [15:0]       rsp_out_handle,
   output logic [15:0]       rsp_out_seq_number,
   output logic [31:0]       rsp_out_timestamp,
   output logic              rsp_last,
   output logic [6:0]        rsp_frames_held,
   output logic              rsp_ready_level
);

   logic [13:0] delay_ff, delay_in;
   logic [6:0]  filter_ff, filter_in;
   logic        mute_ff, mute_in;
   logic [6:0]  low_water_ff, low_water_in;

   jvb_pkg::func_type func_ff, func_in;
   logic [31:0] ts_ff, ts_in;
   logic [15:0] seq_ff, seq_in;
   logic [6:0]  kind_ff, kind_in;
   logic [15:0] handle_ff, handle_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] limit_ff, limit_in;

   jvb_pkg::cnt_type held_ff, held_in;
   jvb_pkg::cnt_type fc_ff, fc_in;
   jvb_pkg::cnt_type idx_ff, idx_in;
   jvb_pkg::cnt_type ptr_ff, ptr_in;
   jvb_pkg::cnt_type drop_ff, drop_in;
   logic        ready_ff, ready_in;
   logic        started_ff, started_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] prev_ts_ff, prev_ts_in;
   logic        found_ff, found_in;
   logic        eq_pair_ff, eq_pair_in;
   logic        eq_ts_ff, eq_ts_in;

   logic [3:0]  resp_status_ff, resp_status_in;
   logic [15:0] resp_handle_ff, resp_handle_in;
   logic [15:0] resp_seq_ff, resp_seq_in;
   logic [31:0] resp_ts_ff, resp_ts_in;
   logic        resp_last_ff, resp_last_in;

   jvb_pkg::entry_type rd_entry;
   jvb_pkg::entry_type wr_entry;
   jvb_pkg::cnt_type   rd_cnt;
   jvb_pkg::cnt_type   wr_cnt;
   logic               wr_en;
   logic [31:0]        elapsed;
   logic [$bits(jvb_pkg::entry_type)-1:0] ram_rdata;

   jvb_ram #(
      .WIDTH($bits(jvb_pkg::entry_type)),
      .DEPTH(jvb_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_cnt[jvb_pkg::IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_cnt[jvb_pkg::IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_entry = ram_rdata;
   assign elapsed = now_ff - start_ff;

   always_comb begin
      stat.func = func_ff;
      stat.mute_drop = mute_ff;
      stat.type_drop = (filter_ff != '0) && (filter_ff != kind_ff);
      stat.not_ready = elapsed < {18'd0, delay_ff};
      stat.held_zero = (held_ff == '0);
      stat.expire_ok = (fc_ff >= jvb_pkg::EXPIRE_MIN_FRAMES);
      stat.scan_at_end = (idx_ff == held_ff);
      case (func_ff)
         jvb_pkg::FN_ENQ: stat.scan_cont = (rd_entry.ts < ts_ff) ||
                                          ((rd_entry.ts == ts_ff) && (rd_entry.seq < seq_ff));
         jvb_pkg::FN_DEQ: stat.scan_cont = (idx_ff == '0) || (rd_entry.ts == prev_ts_ff);
         jvb_pkg::FN_EXP: stat.scan_cont = (rd_entry.ts < limit_ff);
         default: stat.scan_cont = 1'b0;
      endcase
      stat.dup = found_ff && eq_pair_ff;
      stat.full = (held_ff >= jvb_pkg::DEPTH_CNT);
      stat.joins = (found_ff && eq_ts_ff) || ((idx_ff != '0) && (prev_ts_ff == ts_ff));
      stat.up_done = (ptr_ff == idx_ff);
      stat.dlv_last = (jvb_pkg::cnt_type'(ptr_ff + jvb_pkg::cnt_type'(1)) == idx_ff);
      stat.dn_done = (ptr_ff == held_ff);
      stat.m_zero = (idx_ff == '0);
   end

   always_comb begin
      case (cmd.rd_sel)
         jvb_pkg::RD_IDX: rd_cnt = idx_ff;
         jvb_pkg::RD_PTR: rd_cnt = ptr_ff;
         jvb_pkg::RD_PTR_M1: rd_cnt = ptr_ff - jvb_pkg::cnt_type'(1);
         default: rd_cnt = idx_ff;
      endcase
      wr_en = cmd.wr_up || cmd.ins || cmd.dn_step;
      wr_cnt = ptr_ff;
      wr_entry = rd_entry;
      if (cmd.ins) begin
         wr_cnt = idx_ff;
         wr_entry.ts = ts_ff;
         wr_entry.seq = seq_ff;
         wr_entry.handle = handle_ff;
      end else if (cmd.dn_step) begin
         wr_cnt = ptr_ff - idx_ff;
      end
   end

   always_comb begin
      delay_in = delay_ff;
      filter_in = filter_ff;
      mute_in = mute_ff;
      low_water_in = low_water_ff;
      if (csr_wr_en) begin
         case (jvb_pkg::csr_index_type'(csr_index))
            jvb_pkg::CSR_DELAY: delay_in = csr_wr_data;
            jvb_pkg::CSR_PT_FILTER: filter_in = csr_wr_data[6:0];
            jvb_pkg::CSR_MUTE: mute_in = csr_wr_data[0];
            jvb_pkg::CSR_LOW_WATER: low_water_in = csr_wr_data[6:0];
            default: delay_in = delay_ff;
         endcase
      end
   end

   always_comb begin
      func_in = func_ff;
      ts_in = ts_ff;
      seq_in = seq_ff;
      kind_in = kind_ff;
      handle_in = handle_ff;
      now_in = now_ff;
      limit_in = limit_ff;
      if (cmd.load_item) begin
         func_in = jvb_pkg::func_type'(req_func);
         ts_in = req_rtp_timestamp;
         seq_in = req_seq_number;
         kind_in = req_payload_kind;
         handle_in = req_packet_handle;
         now_in = req_now_ms;
         limit_in = req_expire_limit;
      end
   end

   always_comb begin
      held_in = held_ff;
      fc_in = fc_ff;
      idx_in = idx_ff;
      ptr_in = ptr_ff;
      drop_in = drop_ff;
      ready_in = ready_ff;
      started_in = started_ff;
      start_in = start_ff;
      prev_ts_in = prev_ts_ff;
      found_in = found_ff;
      eq_pair_in = eq_pair_ff;
      eq_ts_in = eq_ts_ff;
      if (cmd.set_start && !started_ff) begin
         started_in = 1'b1;
         start_in = now_ff;
      end
      if (cmd.clear_start) begin
         started_in = 1'b0;
         start_in = '0;
      end
      if (cmd.clear_store) begin
         held_in = '0;
         fc_in = '0;
      end
      if (cmd.scan_init) begin
         idx_in = '0;
         drop_in = '0;
      end
      if (cmd.scan_step) begin
         prev_ts_in = rd_entry.ts;
         idx_in = idx_ff + jvb_pkg::cnt_type'(1);
         if ((func_ff == jvb_pkg::FN_EXP) &&
             ((idx_ff == '0) || (rd_entry.ts != prev_ts_ff))) begin
            drop_in = drop_ff + jvb_pkg::cnt_type'(1);
         end
      end
      if (cmd.scan_miss) begin
         found_in = 1'b0;
      end
      if (cmd.scan_stop) begin
         found_in = 1'b1;
         eq_ts_in = (rd_entry.ts == ts_ff);
         eq_pair_in = (rd_entry.ts == ts_ff) && (rd_entry.seq == seq_ff);
      end
      if (cmd.up_init) begin
         ptr_in = held_ff;
      end
      if (cmd.wr_up) begin
         ptr_in = ptr_ff - jvb_pkg::cnt_type'(1);
      end
      if (cmd.ins) begin
         held_in = held_ff + jvb_pkg::cnt_type'(1);
         if (!stat.joins) begin
            fc_in = fc_ff + jvb_pkg::cnt_type'(1);
            ready_in = ({1'b0, fc_ff} + 8'd1) >= {1'b0, low_water_ff};
         end
      end
      if (cmd.dlv_init) begin
         ptr_in = '0;
         if (fc_ff != '0) fc_in = fc_ff - jvb_pkg::cnt_type'(1);
      end
      if (cmd.dlv_next) begin
         ptr_in = ptr_ff + jvb_pkg::cnt_type'(1);
      end
      if (cmd.dn_init) begin
         ptr_in = idx_ff;
         if (func_ff == jvb_pkg::FN_EXP) fc_in = fc_ff - drop_ff;
      end
      if (cmd.dn_step) begin
         ptr_in = ptr_ff + jvb_pkg::cnt_type'(1);
      end
      if (cmd.dn_finish) begin
         held_in = held_ff - idx_ff;
      end
   end

   always_comb begin
      resp_status_in = resp_status_ff;
      resp_handle_in = resp_handle_ff;
      resp_seq_in = resp_seq_ff;
      resp_ts_in = resp_ts_ff;
      resp_last_in = resp_last_ff;
      if (cmd.resp_load) begin
         resp_status_in = cmd.resp_code;
         if (cmd.resp_entry) begin
            resp_handle_in = rd_entry.handle;
            resp_seq_in = rd_entry.seq;
            resp_ts_in = rd_entry.ts;
            resp_last_in = stat.dlv_last;
         end else begin
            resp_handle_in = '0;
            resp_seq_in = '0;
            resp_ts_in = '0;
            resp_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= jvb_pkg::DELAY_RESET;
         filter_ff <= '0;
         mute_ff <= 1'b0;
         low_water_ff <= jvb_pkg::LOW_WATER_RESET;
         held_ff <= '0;
         fc_ff <= '0;
         ready_ff <= 1'b0;
         started_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         delay_ff <= delay_in;
         filter_ff <= filter_in;
         mute_ff <= mute_in;
         low_water_ff <= low_water_in;
         held_ff <= held_in;
         fc_ff <= fc_in;
         ready_ff <= ready_in;
         started_ff <= started_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      ts_ff <= ts_in;
      seq_ff <= seq_in;
      kind_ff <= kind_in;
      handle_ff <= handle_in;
      now_ff <= now_in;
      limit_ff <= limit_in;
      idx_ff <= idx_in;
      ptr_ff <= ptr_in;
      drop_ff <= drop_in;
      prev_ts_ff <= prev_ts_in;
      found_ff <= found_in;
      eq_pair_ff <= eq_pair_in;
      eq_ts_ff <= eq_ts_in;
      resp_status_ff <= resp_status_in;
      resp_handle_ff <= resp_handle_in;
      resp_seq_ff <= resp_seq_in;
      resp_ts_ff <= resp_ts_in;
      resp_last_ff <= resp_last_in;
   end

   assign rsp_status = resp_status_ff;
   assign rsp_out_handle = resp_handle_ff;
   assign rsp_out_seq_number = resp_seq_ff;
   assign rsp_out_timestamp = resp_ts_ff;
   assign rsp_last = resp_last_ff;
   assign rsp_frames_held = jvb_pkg::frames_type'(fc_ff);
   assign rsp_ready_level = ready_ff;

   `JVB_ASSERT_NOW(a_held_max, clock, reset, 1'b1, held_ff <= jvb_pkg::DEPTH_CNT, "held over depth")
   `JVB_ASSERT_NOW(a_frames_le_held, clock, reset, 1'b1, fc_ff <= held_ff, "frames exceed packets")
   `JVB_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear_store, held_ff == '0, "clear failed")

endmodule

// ===== src/video_jitter_buffer.sv =====
// Enqueue scans held packets, shifts later ones up a slot, then inserts. Dequeue scans
// the first frame, sends its items one at a time, each waiting for rsp_ready, and then
// compacts the store; expire does the same without the item phase. One request at a time.
// Synchronous active-high reset restores CSR defaults, clears packet and frame counts,
// ready and start flags and start time; other registers and store contents stay.
module video_jitter_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_rtp_timestamp,
   input  logic [15:0] req_seq_number,
   input  logic [6:0]  req_payload_kind,
   input  logic [15:0] req_packet_handle,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_expire_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_out_handle,
   output logic [15:0] rsp_out_seq_number,
   output logic [31:0] rsp_out_timestamp,
   output logic        rsp_last,
   output logic [6:0]  rsp_frames_held,
   output logic        rsp_ready_level
);

   jvb_pkg::cmd_type  cmd;
   jvb_pkg::stat_type stat;

   jvb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   jvb_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_func           (req_func),
      .req_rtp_timestamp  (req_rtp_timestamp),
      .req_seq_number     (req_seq_number),
      .req_payload_kind   (req_payload_kind),
      .req_packet_handle  (req_packet_handle),
      .req_now_ms         (req_now_ms),
      .req_expire_limit   (req_expire_limit),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_seq_number (rsp_out_seq_number),
      .rsp_out_timestamp  (rsp_out_timestamp),
      .rsp_last           (rsp_last),
      .rsp_frames_held    (rsp_frames_held),
      .rsp_ready_level    (rsp_ready_level)
   );

endmodule
